// File: hw/rtl/im2col_window_address_generator_core_macros.svh
// assertion macros shared by the im2col window address generator modules
// no dependencies; included by modules that carry concurrent checks
`ifndef IM2COL_WINDOW_ADDRESS_GENERATOR_CORE_MACROS_SVH
`define IM2COL_WINDOW_ADDRESS_GENERATOR_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define IWAG_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define IWAG_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/iwag_pkg.sv
// shared types, widths and register codes of the im2col window address generator
// no dependencies; used by all modules of the block
package iwag_pkg;

    // field widths
    localparam int ROW_W   = 9;
    localparam int COL_W   = 9;
    localparam int CH_W    = 6;
    localparam int BATCH_W = 6;
    localparam int SRC_W   = 30;
    localparam int WPOS_W  = 12;
    localparam int DEST_W  = 36;

    // configuration widths
    localparam int DIM_W   = 10;
    localparam int DEPTH_W = 7;
    localparam int KER_W   = 4;
    localparam int KCNT_W  = KER_W - 1;
    localparam int CFG_W   = 10;
    localparam int IDX_W   = 3;

    // signed tap coordinate: pixel coordinate plus kernel offset minus half kernel
    localparam int COORD_W = 11;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 80;
    localparam int OUT_TUSER_W = 2;
    localparam int TUSER_PAD   = 0;
    localparam int TUSER_OOR   = 1;

    localparam int Q_DEPTH = 4;

    // register indexes
    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [IDX_W-1:0] REG_IMAGE_DEPTH   = 3'd2;
    localparam logic [IDX_W-1:0] REG_KERNEL_WIDTH  = 3'd3;
    localparam logic [IDX_W-1:0] REG_KERNEL_HEIGHT = 3'd4;

    // reset values of the registers
    localparam int RESET_WIDTH   = 28;
    localparam int RESET_HEIGHT  = 28;
    localparam int RESET_DEPTH   = 1;
    localparam int RESET_KWIDTH  = 3;
    localparam int RESET_KHEIGHT = 3;

    typedef struct packed {
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [DEPTH_W-1:0] depth;
        logic [KER_W-1:0]   kw;
        logic [KER_W-1:0]   kh;
    } cfg_t;

    // one work descriptor per input item, front to back
    typedef struct packed {
        logic                      oor;
        logic signed [COORD_W-1:0] y0;
        logic signed [COORD_W-1:0] x0;
        logic [SRC_W-1:0]          line_base;
        logic [WPOS_W-1:0]         wpos_base;
        logic [DEST_W-1:0]         dest_base;
    } entry_t;

    // zero counts as one, anything above hi counts as hi
    function automatic logic [15:0] clamp_size(input logic [15:0] v, input logic [15:0] hi);
        logic [15:0] r;
        if (v == 16'd0) begin
            r = 16'd1;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/iwag_queue.sv
// descriptor queue between the address front end and the tap sequencer
// depends on iwag_pkg and the assertion macro header
`include "im2col_window_address_generator_core_macros.svh"

module iwag_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  iwag_pkg::entry_t entry_in,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output iwag_pkg::entry_t entry_out
);

    localparam int PTR_W = $clog2(iwag_pkg::Q_DEPTH);
    localparam int CNT_W = $clog2(iwag_pkg::Q_DEPTH + 1);

    iwag_pkg::entry_t  mem_reg [iwag_pkg::Q_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full      = (count_reg == CNT_W'(iwag_pkg::Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign entry_out = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= entry_in;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `IWAG_ASSERT_IMP(a_no_push_full, aclk, aresetn, push, !full, "push into full queue")
    `IWAG_ASSERT_NXT(a_count_up, aclk, aresetn, push && !pop,
        count_reg == $past(count_reg) + 1'b1, "queue count lost a push")

endmodule

// File: hw/rtl/iwag_front.sv
// front end: accepts pixel items, checks ranges and builds the base addresses
// over four registered stages; depends on iwag_pkg
module iwag_front #(
    parameter int MAX_BATCH = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  iwag_pkg::cfg_t                      cfg,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [iwag_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                q_push,
    output iwag_pkg::entry_t                    q_entry,
    input  logic                                q_full
);

    localparam int PLANE_W = 2 * iwag_pkg::DIM_W;
    localparam int TAPS_W  = 2 * iwag_pkg::KER_W;
    localparam int BDC_W   = iwag_pkg::BATCH_W + iwag_pkg::DEPTH_W + 1;
    localparam int PIX_W   = iwag_pkg::BATCH_W + PLANE_W + 1;
    localparam int WIN_W   = TAPS_W + iwag_pkg::DEPTH_W;
    localparam int YW_W    = 2 * iwag_pkg::COORD_W;

    logic                          adv;
    logic [iwag_pkg::ROW_W-1:0]    in_row;
    logic [iwag_pkg::COL_W-1:0]    in_col;
    logic [iwag_pkg::CH_W-1:0]     in_ch;
    logic [iwag_pkg::BATCH_W-1:0]  in_b;
    logic [iwag_pkg::KCNT_W-1:0]   half_w;
    logic [iwag_pkg::KCNT_W-1:0]   half_h;
    logic signed [iwag_pkg::COORD_W-1:0] y0_c;
    logic signed [iwag_pkg::COORD_W-1:0] x0_c;
    logic                          oor_c;

    // stage 1
    logic                          v1_reg;
    logic                          oor1_reg;
    logic signed [iwag_pkg::COORD_W-1:0] y01_reg, x01_reg;
    logic signed [YW_W-1:0]        y0w1_reg;
    logic [PLANE_W-1:0]            plane1_reg;
    logic [PLANE_W-1:0]            rowcol1_reg;
    logic [TAPS_W-1:0]             taps1_reg;
    logic [BDC_W-1:0]              bdc1_reg;
    logic [iwag_pkg::BATCH_W-1:0]  b1_reg;
    logic [iwag_pkg::CH_W-1:0]     ch1_reg;
    // stage 2
    logic                          v2_reg;
    logic                          oor2_reg;
    logic signed [iwag_pkg::COORD_W-1:0] y02_reg, x02_reg;
    logic signed [YW_W-1:0]        y0w2_reg;
    logic [PIX_W-1:0]              pix2_reg;
    logic [WIN_W-1:0]              win2_reg;
    logic [iwag_pkg::SRC_W-1:0]    src2_reg;
    logic [iwag_pkg::WPOS_W-1:0]   wbase2_reg;
    // stage 3
    logic                          v3_reg;
    logic                          oor3_reg;
    logic signed [iwag_pkg::COORD_W-1:0] y03_reg, x03_reg;
    logic [iwag_pkg::DEST_W-1:0]   pixbase3_reg;
    logic [iwag_pkg::SRC_W-1:0]    line3_reg;
    logic [iwag_pkg::WPOS_W-1:0]   wbase3_reg;
    // stage 4, the descriptor
    logic                          v4_reg;
    iwag_pkg::entry_t              ent4_reg;

    logic [PLANE_W+BDC_W-1:0]      src_prod;
    logic [PIX_W+WIN_W-1:0]        pix_prod;
    logic [TAPS_W+iwag_pkg::CH_W-1:0] wbase_prod;

    // the whole pipe freezes only when the descriptor cannot be queued
    assign adv      = !(v4_reg && q_full);
    assign s_tready = adv && aresetn;
    assign q_push   = v4_reg && !q_full;
    assign q_entry  = ent4_reg;

    assign in_row = s_tdata[8:0];
    assign in_col = s_tdata[17:9];
    assign in_ch  = s_tdata[23:18];
    assign in_b   = s_tdata[29:24];
    assign half_w = cfg.kw[iwag_pkg::KER_W-1:1];
    assign half_h = cfg.kh[iwag_pkg::KER_W-1:1];

    assign y0_c = iwag_pkg::COORD_W'(in_row) - iwag_pkg::COORD_W'(half_h);
    assign x0_c = iwag_pkg::COORD_W'(in_col) - iwag_pkg::COORD_W'(half_w);

    assign oor_c = ({1'b0, in_row} >= cfg.height) || ({1'b0, in_col} >= cfg.width)
                || ({1'b0, in_ch} >= cfg.depth) || (32'(in_b) >= 32'(MAX_BATCH));

    assign src_prod   = bdc1_reg * plane1_reg;
    assign pix_prod   = pix2_reg * win2_reg;
    assign wbase_prod = ch1_reg * taps1_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            oor1_reg    <= oor_c;
            y01_reg     <= y0_c;
            x01_reg     <= x0_c;
            y0w1_reg    <= y0_c * $signed({1'b0, cfg.width});
            plane1_reg  <= cfg.width * cfg.height;
            rowcol1_reg <= PLANE_W'(in_row * cfg.width) + PLANE_W'(in_col);
            taps1_reg   <= cfg.kw * cfg.kh;
            bdc1_reg    <= BDC_W'(in_b * cfg.depth) + BDC_W'(in_ch);
            b1_reg      <= in_b;
            ch1_reg     <= in_ch;

            oor2_reg    <= oor1_reg;
            y02_reg     <= y01_reg;
            x02_reg     <= x01_reg;
            y0w2_reg    <= y0w1_reg;
            pix2_reg    <= PIX_W'(b1_reg * plane1_reg) + PIX_W'(rowcol1_reg);
            win2_reg    <= taps1_reg * cfg.depth;
            src2_reg    <= src_prod[iwag_pkg::SRC_W-1:0];
            wbase2_reg  <= wbase_prod[iwag_pkg::WPOS_W-1:0];

            oor3_reg     <= oor2_reg;
            y03_reg      <= y02_reg;
            x03_reg      <= x02_reg;
            pixbase3_reg <= pix_prod[iwag_pkg::DEST_W-1:0];
            // start of the first tap row, may wrap when that row is above the image
            line3_reg    <= src2_reg
                          + {{(iwag_pkg::SRC_W-YW_W){y0w2_reg[YW_W-1]}}, y0w2_reg};
            wbase3_reg   <= wbase2_reg;

            ent4_reg.oor       <= oor3_reg;
            ent4_reg.y0        <= y03_reg;
            ent4_reg.x0        <= x03_reg;
            ent4_reg.line_base <= line3_reg;
            ent4_reg.wpos_base <= wbase3_reg;
            ent4_reg.dest_base <= pixbase3_reg + iwag_pkg::DEST_W'(wbase3_reg);
        end
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

endmodule

// File: hw/rtl/iwag_back.sv
// back end: walks the kernel taps of each descriptor, one result per tap, and drives
// the output register; depends on iwag_pkg and the assertion macro header
`include "im2col_window_address_generator_core_macros.svh"

module iwag_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  iwag_pkg::cfg_t                      cfg,
    input  logic                                q_valid,
    input  iwag_pkg::entry_t                    q_entry,
    output logic                                q_pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [iwag_pkg::OUT_TDATA_W-1:0]    m_tdata,  // source_addr, window_pos, dest_addr
    output logic [iwag_pkg::OUT_TUSER_W-1:0]    m_tuser,  // is_padding, out_of_range
    output logic                                m_tlast
);

    localparam int CW = iwag_pkg::COORD_W;

    logic                              active_reg;
    logic [iwag_pkg::KCNT_W-1:0]       m_reg, n_reg;
    logic signed [CW-1:0]              y_reg, x_reg, xs_reg;
    logic [iwag_pkg::SRC_W-1:0]        line_reg;
    logic [iwag_pkg::WPOS_W-1:0]       wpos_reg;
    logic [iwag_pkg::DEST_W-1:0]       dest_reg;
    logic                              oor_reg;

    logic                              m_tvalid_reg;
    logic [iwag_pkg::OUT_TDATA_W-1:0]  m_tdata_reg;
    logic [iwag_pkg::OUT_TUSER_W-1:0]  m_tuser_reg;
    logic                              m_tlast_reg;

    logic                              emit;
    logic                              row_end;
    logic                              tap_last;
    logic                              load;
    logic                              pad;
    logic [iwag_pkg::SRC_W-1:0]        src_val;
    logic [iwag_pkg::SRC_W-1:0]        src_out;
    logic [iwag_pkg::DEST_W-1:0]       dest_out;

    assign emit     = active_reg && (!m_tvalid_reg || m_tready);
    assign row_end  = ({1'b0, n_reg} == cfg.kw - 1'b1);
    assign tap_last = row_end && ({1'b0, m_reg} == cfg.kh - 1'b1);
    // next descriptor loads while the last tap of the current one goes out
    assign load     = q_valid && (!active_reg || (emit && tap_last));
    assign q_pop    = load;

    assign pad = y_reg[CW-1] || (y_reg[CW-2:0] >= cfg.height)
              || x_reg[CW-1] || (x_reg[CW-2:0] >= cfg.width);
    assign src_val  = line_reg + iwag_pkg::SRC_W'(x_reg[CW-2:0]);
    assign src_out  = (oor_reg || pad) ? '0 : src_val;
    assign dest_out = oor_reg ? '0 : dest_reg;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            m_reg    <= '0;
            n_reg    <= '0;
            y_reg    <= q_entry.y0;
            x_reg    <= q_entry.x0;
            xs_reg   <= q_entry.x0;
            line_reg <= q_entry.line_base;
            wpos_reg <= q_entry.wpos_base;
            dest_reg <= q_entry.dest_base;
            oor_reg  <= q_entry.oor;
        end else if (emit) begin
            wpos_reg <= wpos_reg + 1'b1;
            dest_reg <= dest_reg + 1'b1;
            if (row_end) begin
                n_reg    <= '0;
                m_reg    <= m_reg + 1'b1;
                y_reg    <= y_reg + 1'b1;
                x_reg    <= xs_reg;
                line_reg <= line_reg + iwag_pkg::SRC_W'(cfg.width);
            end else begin
                n_reg <= n_reg + 1'b1;
                x_reg <= x_reg + 1'b1;
            end
        end
        if (emit) begin
            m_tdata_reg <= {2'b00, dest_out, wpos_reg, src_out};
            m_tuser_reg[iwag_pkg::TUSER_PAD] <= pad && !oor_reg;
            m_tuser_reg[iwag_pkg::TUSER_OOR] <= oor_reg;
            m_tlast_reg <= tap_last;
        end
        if (!aresetn) begin
            active_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (load) begin
                active_reg <= 1'b1;
            end else if (emit && tap_last) begin
                active_reg <= 1'b0;
            end
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    `IWAG_ASSERT_IMP(a_pad_src_zero, aclk, aresetn,
        m_tvalid_reg && m_tuser_reg[iwag_pkg::TUSER_PAD],
        m_tdata_reg[iwag_pkg::SRC_W-1:0] == '0, "padding tap with nonzero source")
    `IWAG_ASSERT_IMP(a_oor_clean, aclk, aresetn,
        m_tvalid_reg && m_tuser_reg[iwag_pkg::TUSER_OOR],
        !m_tuser_reg[iwag_pkg::TUSER_PAD] && (m_tdata_reg[77:42] == '0),
        "out of range result with padding or destination")
    `IWAG_ASSERT_NXT(a_drain_idle, aclk, aresetn,
        m_tvalid_reg && m_tready && !active_reg, !m_tvalid_reg,
        "result appeared with no tap in progress")

endmodule

// File: hw/rtl/im2col_window_address_generator_core.sv
// im2col window address generator, same padding; one result per kernel tap.
// an item's first result passes the four front stages, descriptor queue, tap registers
// and output register; results go out one per cycle while m_tready allows, and the
// address pipe takes a new item every cycle unless a full descriptor queue stalls it.
// reset (aresetn, synchronous): queue and outputs empty, registers to 28,28,1,3,3.
module im2col_window_address_generator_core #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int MAX_DEPTH  = 64,
    parameter int MAX_KERNEL = 8,
    parameter int MAX_BATCH  = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [iwag_pkg::IDX_W-1:0]          cfg_index,
    input  logic [iwag_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [iwag_pkg::IN_TDATA_W-1:0]     s_tdata,  // pixel_row, pixel_col, channel, batch_index
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [iwag_pkg::OUT_TDATA_W-1:0]    m_tdata,  // source_addr, window_pos, dest_addr
    output logic [iwag_pkg::OUT_TUSER_W-1:0]    m_tuser,  // is_padding, out_of_range
    output logic                                m_tlast
);

    iwag_pkg::cfg_t    cfg_reg;
    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_valid;
    iwag_pkg::entry_t  q_in;
    iwag_pkg::entry_t  q_out;

    assign cfg_ready = aresetn;

    // registers hold clamped sizes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.width  <= iwag_pkg::DIM_W'(iwag_pkg::clamp_size(
                                  16'(iwag_pkg::RESET_WIDTH), 16'(MAX_WIDTH)));
            cfg_reg.height <= iwag_pkg::DIM_W'(iwag_pkg::clamp_size(
                                  16'(iwag_pkg::RESET_HEIGHT), 16'(MAX_HEIGHT)));
            cfg_reg.depth  <= iwag_pkg::DEPTH_W'(iwag_pkg::clamp_size(
                                  16'(iwag_pkg::RESET_DEPTH), 16'(MAX_DEPTH)));
            cfg_reg.kw     <= iwag_pkg::KER_W'(iwag_pkg::clamp_size(
                                  16'(iwag_pkg::RESET_KWIDTH), 16'(MAX_KERNEL)));
            cfg_reg.kh     <= iwag_pkg::KER_W'(iwag_pkg::clamp_size(
                                  16'(iwag_pkg::RESET_KHEIGHT), 16'(MAX_KERNEL)));
        end else if (cfg_valid) begin
            case (cfg_index)
                iwag_pkg::REG_IMAGE_WIDTH: begin
                    cfg_reg.width <= iwag_pkg::DIM_W'(iwag_pkg::clamp_size(
                                         16'(cfg_data), 16'(MAX_WIDTH)));
                end
                iwag_pkg::REG_IMAGE_HEIGHT: begin
                    cfg_reg.height <= iwag_pkg::DIM_W'(iwag_pkg::clamp_size(
                                          16'(cfg_data), 16'(MAX_HEIGHT)));
                end
                iwag_pkg::REG_IMAGE_DEPTH: begin
                    cfg_reg.depth <= iwag_pkg::DEPTH_W'(iwag_pkg::clamp_size(
                        16'(cfg_data[iwag_pkg::DEPTH_W-1:0]), 16'(MAX_DEPTH)));
                end
                iwag_pkg::REG_KERNEL_WIDTH: begin
                    cfg_reg.kw <= iwag_pkg::KER_W'(iwag_pkg::clamp_size(
                        16'(cfg_data[iwag_pkg::KER_W-1:0]), 16'(MAX_KERNEL)));
                end
                iwag_pkg::REG_KERNEL_HEIGHT: begin
                    cfg_reg.kh <= iwag_pkg::KER_W'(iwag_pkg::clamp_size(
                        16'(cfg_data[iwag_pkg::KER_W-1:0]), 16'(MAX_KERNEL)));
                end
                default: begin
                end
            endcase
        end
    end

    iwag_front #(
        .MAX_BATCH (MAX_BATCH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_push   (q_push),
        .q_entry  (q_in),
        .q_full   (q_full)
    );

    iwag_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .entry_in  (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .entry_out (q_out)
    );

    iwag_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_entry  (q_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
